@@ sv/ppfe_pkg.sv @@
// shared constants, codes and types for the pipe pool fifo engine
package ppfe_pkg;

	localparam int NUM_PIPES  = 16;
	localparam int PIPE_DEPTH = 4096;
	localparam int REF_MAX    = 255;

	localparam int PIPE_W = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
	localparam int PTR_W  = $clog2(PIPE_DEPTH);
	localparam int FILL_W = $clog2(PIPE_DEPTH + 1);
	localparam int REF_W  = $clog2(REF_MAX + 1);
	localparam int ADDR_W = PIPE_W + PTR_W;

	// field widths fixed by the stream format
	localparam int CMD_W   = 3;
	localparam int INDEX_W = 4;
	localparam int BYTE_W  = 8;
	localparam int STAT_W  = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 3'd0,
		CMD_ADD   = 3'd1,
		CMD_CLOSE = 3'd2,
		CMD_READ  = 3'd3,
		CMD_WRITE = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK         = 3'd0,
		ST_NO_FREE    = 3'd1,
		ST_EOF        = 3'd2,
		ST_EMPTY_WAIT = 3'd3,
		ST_FULL_WAIT  = 3'd4,
		ST_BROKEN     = 3'd5,
		ST_NOT_IN_USE = 3'd6
	} status_t;

	typedef logic [PIPE_W-1:0] pipe_t;
	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [FILL_W-1:0] fill_t;
	typedef logic [REF_W-1:0]  ref_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// ring store access from the control stage
	typedef struct packed {
		logic              wr_en;
		addr_t             wr_addr;
		logic [BYTE_W-1:0] wr_data;
		logic              rd_en;
		addr_t             rd_addr;
	} ring_req_t;

endpackage

@@ sv/ppfe_ring.sv @@
// byte ring store shared by all pipes, one write and one registered read per cycle
module ppfe_ring (
	input  logic                   clk,
	input  ppfe_pkg::ring_req_t    req,
	output logic [7:0]             rd_data
);
	import ppfe_pkg::*;

	logic [BYTE_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

@@ sv/pipe_pool_fifo_engine_top.sv @@
// top level of the pipe pool fifo engine: command stage, pipe state and result stage
//
// a pool of byte pipes, each a ring of PIPE_DEPTH bytes in one shared store with its
// head, tail, fill count, reader and writer counts and in-use mark held in flip-flops.
// every request (allocate, add reference, close reference, read byte, write byte)
// gives exactly one result. one request is taken per cycle while the result register
// is empty or its result is taken: the request is registered, then decoded
// against the pipe state and applied in one pass while the ring store is read or
// written, and the status lands in the result register together with the
// registered byte from the store's single read port. the ring store has no reset;
// a byte is only read after it was written
module pipe_pool_fifo_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	// request: tdata = pipe_index[3:0], write_data[11:4], zero[15:12]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,
	// request: tuser = command[2:0], end_select[3]
	input  logic [3:0]  s_tuser,
	// result: tdata = read_data[7:0], allocated_index[11:8], zero[15:12]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	// result: tuser = status[2:0]
	output logic [2:0]  m_tuser
);
	import ppfe_pkg::*;

	// request stage
	logic               v_s1;
	logic [CMD_W-1:0]   cmd_s1;
	logic [INDEX_W-1:0] idx_s1;
	logic               end_s1;
	logic [BYTE_W-1:0]  wd_s1;

	// result stage
	logic               v_s2;
	status_t            status_s2;
	logic [INDEX_W-1:0] aidx_s2;
	logic               rok_s2;

	// per-pipe state
	ptr_t  head_q   [NUM_PIPES];
	ptr_t  tail_q   [NUM_PIPES];
	fill_t fill_q   [NUM_PIPES];
	ref_t  rrefs_q  [NUM_PIPES];
	ref_t  wrefs_q  [NUM_PIPES];
	logic  in_use_q [NUM_PIPES];

	logic       adv;
	logic       fire;
	pipe_t      idx_p;
	logic       hit;
	logic       free_found;
	pipe_t      free_i;
	ref_t       r_cur, w_cur, r_new, w_new;
	ptr_t       head_cur, tail_cur;
	fill_t      fill_cur;
	status_t    status;
	logic       do_alloc, do_add, do_close, do_read, do_write;
	ring_req_t  ring_req;
	logic [7:0] ring_rd;

	// the result register moves when empty or taken; the request stage follows it
	assign adv      = !v_s2 || m_tready;
	assign s_tready = !v_s1 || adv;
	assign fire     = v_s1 && adv;

	always_comb begin
		idx_p      = PIPE_W'(idx_s1);
		hit        = (32'(idx_s1) < NUM_PIPES) && in_use_q[idx_p];
		// lowest free pipe: scan from the top so the lowest one wins
		free_found = 1'b0;
		free_i     = '0;
		for (int i = NUM_PIPES - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_found = 1'b1;
				free_i     = PIPE_W'(i);
			end
		end
		r_cur    = rrefs_q[idx_p];
		w_cur    = wrefs_q[idx_p];
		head_cur = head_q[idx_p];
		tail_cur = tail_q[idx_p];
		fill_cur = fill_q[idx_p];
		// counts after a close, floored at zero
		r_new = (!end_s1 && r_cur != '0) ? r_cur - 1'b1 : r_cur;
		w_new = (end_s1 && w_cur != '0) ? w_cur - 1'b1 : w_cur;

		status   = ST_OK;
		do_alloc = 1'b0;
		do_add   = 1'b0;
		do_close = 1'b0;
		do_read  = 1'b0;
		do_write = 1'b0;
		case (cmd_s1)
			CMD_ALLOC: begin
				if (free_found) do_alloc = 1'b1;
				else status = ST_NO_FREE;
			end
			CMD_ADD: begin
				if (!hit) status = ST_NOT_IN_USE;
				else do_add = 1'b1;
			end
			CMD_CLOSE: begin
				if (!hit) status = ST_NOT_IN_USE;
				else do_close = 1'b1;
			end
			CMD_READ: begin
				if (!hit) status = ST_NOT_IN_USE;
				else if (fill_cur == '0) status = (w_cur == '0) ? ST_EOF : ST_EMPTY_WAIT;
				else do_read = 1'b1;
			end
			CMD_WRITE: begin
				// no reader is checked before fullness
				if (!hit) status = ST_NOT_IN_USE;
				else if (r_cur == '0) status = ST_BROKEN;
				else if (fill_cur >= FILL_W'(PIPE_DEPTH)) status = ST_FULL_WAIT;
				else do_write = 1'b1;
			end
			default: status = ST_OK; // unused codes do nothing
		endcase

		ring_req.wr_en   = fire && do_write;
		ring_req.wr_addr = {idx_p, tail_cur};
		ring_req.wr_data = wd_s1;
		ring_req.rd_en   = fire && do_read;
		ring_req.rd_addr = {idx_p, head_cur};
	end

	ppfe_ring u_ring (
		.clk     (clk),
		.req     (ring_req),
		.rd_data (ring_rd)
	);

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1 <= s_tuser[2:0];
			end_s1 <= s_tuser[3];
			idx_s1 <= s_tdata[3:0];
			wd_s1  <= s_tdata[11:4];
		end
	end

	// pipe state update, applied when the request moves on to the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PIPES; i++) begin
				head_q[i]   <= '0;
				tail_q[i]   <= '0;
				fill_q[i]   <= '0;
				rrefs_q[i]  <= '0;
				wrefs_q[i]  <= '0;
				in_use_q[i] <= 1'b0;
			end
		end else if (fire) begin
			if (do_alloc) begin
				head_q[free_i]   <= '0;
				tail_q[free_i]   <= '0;
				fill_q[free_i]   <= '0;
				rrefs_q[free_i]  <= REF_W'(1);
				wrefs_q[free_i]  <= REF_W'(1);
				in_use_q[free_i] <= 1'b1;
			end
			if (do_add) begin
				// counts saturate at the maximum
				if (end_s1) begin
					if (w_cur < REF_W'(REF_MAX)) wrefs_q[idx_p] <= w_cur + 1'b1;
				end else begin
					if (r_cur < REF_W'(REF_MAX)) rrefs_q[idx_p] <= r_cur + 1'b1;
				end
			end
			if (do_close) begin
				rrefs_q[idx_p] <= r_new;
				wrefs_q[idx_p] <= w_new;
				if (r_new == '0 && w_new == '0) in_use_q[idx_p] <= 1'b0;
			end
			if (do_read) begin
				head_q[idx_p] <= (head_cur == PTR_W'(PIPE_DEPTH - 1)) ? '0 : head_cur + 1'b1;
				fill_q[idx_p] <= fill_cur - 1'b1;
			end
			if (do_write) begin
				tail_q[idx_p] <= (tail_cur == PTR_W'(PIPE_DEPTH - 1)) ? '0 : tail_cur + 1'b1;
				fill_q[idx_p] <= fill_cur + 1'b1;
			end
		end
	end

	// result register; the read byte sits in the store's output register alongside
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s2 <= status;
			aidx_s2   <= do_alloc ? INDEX_W'(free_i) : '0;
			rok_s2    <= do_read;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tuser  = status_s2;
	assign m_tdata  = {4'b0, aidx_s2, rok_s2 ? ring_rd : 8'h00};

endmodule
